// ===== rtl/ptcp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptcp_pkg
// Shared constants and types for the triangle closest-point pipeline.
// ----------------------------------------------------------------------------
package ptcp_pkg;

    localparam int COORD_BITS_DEF       = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    // source of one output weight
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_ONE,
        SEL_QA,
        SEL_QB,
        SEL_INV_QA
    } sel_t;

    // nearest feature code
    typedef enum logic [2:0] {
        FEAT_VA,
        FEAT_VB,
        FEAT_VC,
        FEAT_AB,
        FEAT_AC,
        FEAT_BC,
        FEAT_IN
    } feat_t;

    // region decision carried down the pipeline
    typedef struct packed {
        sel_t  s_sel;
        sel_t  t_sel;
        feat_t feature;
        logic  degen;
    } ctl_t;

endpackage

// ===== rtl/point_triangle_closest_point.sv =====
// ----------------------------------------------------------------------------
// point_triangle_closest_point
// Fully pipelined closest point on a 3-D triangle, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one beat carries query point P and vertices A, B, C,
//   twelve signed COORD_BITS coordinates. Output channel m_*: one beat carries
//   the nearest point, the squared distance, the weights s (A->B) and t (A->C)
//   in Q1.WEIGHT_FRAC_BITS, and in m_tuser the feature code and the
//   degenerate flag. Every input beat yields exactly one output beat, in order.
// Pipeline: eight stages build the Gram terms and pick the region,
//   WEIGHT_FRAC_BITS + 2 stages form the weight quotients one bit per stage
//   (restoring divider, two lanes), five stages rebuild the point and the
//   distance.
// Throughput: one beat per cycle while m_tready is high; a stage takes a
//   new item whenever it is empty or the next stage moves.
// Reset: rst_n clears all stage valid bits; data registers are not reset.
// Stall: when m_tready is low the last stage holds; earlier stages keep
//   advancing into empty slots, so s_tready drops only once every stage
//   holds an item. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module point_triangle_closest_point #(
    parameter int COORD_BITS       = ptcp_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = ptcp_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // point_x, point_y, point_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // near_x, near_y, near_z, dist_squared, weight_s, weight_t
    output logic [((5*COORD_BITS+2*WEIGHT_FRAC_BITS+4+7)/8)*8-1:0] m_tdata,
    // feature, degenerate
    output logic [3:0] m_tuser
);
    import ptcp_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int W     = WEIGHT_FRAC_BITS;
    localparam int E     = C + 1;          // edge / difference width
    localparam int SQW   = 2 * E;          // product of two differences
    localparam int DW    = 2 * C + 4;      // Gram terms a00..b1
    localparam int NDW   = DW + 2;         // sums of Gram terms
    localparam int H     = DW / 2;         // split point of wide products
    localparam int PPW   = DW + 1;         // partial product
    localparam int PW    = 2 * DW + 2;     // det, s, t
    localparam int DNW   = PW - 1;         // positive divisor
    localparam int DVW   = PW + W + 1;     // divider remainder
    localparam int QW    = W + 2;          // quotient bits
    localparam int WW    = W + 1;          // weight width
    localparam int MW    = W + E + 1;      // weight times edge
    localparam int AW    = MW + 1;         // sum of two of those
    localparam int DSW   = 2 * C + 2;      // squared distance
    localparam int OUT_W = ((5*C+2*W+4+7)/8)*8;

    localparam int ST_DIFF = 0;
    localparam int ST_PROD = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_PART = 3;
    localparam int ST_WIDE = 4;
    localparam int ST_DETS = 5;
    localparam int ST_REG  = 6;
    localparam int ST_CLMP = 7;
    localparam int ST_DIV  = 8;
    localparam int DN      = QW;
    localparam int ST_SEL  = ST_DIV + DN;
    localparam int ST_MUL  = ST_SEL + 1;
    localparam int ST_NEAR = ST_MUL + 1;
    localparam int ST_SQ   = ST_NEAR + 1;
    localparam int ST_OUT  = ST_SQ + 1;
    localparam int NS      = ST_OUT + 1;

    // Gram term indexes
    localparam int Q_A00 = 0;
    localparam int Q_A01 = 1;
    localparam int Q_A11 = 2;
    localparam int Q_B0  = 3;
    localparam int Q_B1  = 4;

    // wide products: a00*a11, a01*a01, a01*b1, a11*b0, a01*b0, a00*b1
    localparam int PX [6] = '{Q_A00, Q_A01, Q_A01, Q_A11, Q_A01, Q_A00};
    localparam int PY [6] = '{Q_A11, Q_A01, Q_B1,  Q_B0,  Q_B0,  Q_B1};

    localparam logic [AW-1:0] HALF       = AW'(1) << (W - 1);
    localparam logic signed [AW-1:0] NLO = AW'(-(2 ** (C - 1)));
    localparam logic signed [AW-1:0] NHI = AW'((2 ** (C - 1)) - 1);

    typedef struct packed {
        logic [2:0][C-1:0] va;
        logic [2:0][C-1:0] pt;
        logic [2:0][E-1:0] e0;
        logic [2:0][E-1:0] e1;
    } geo_t;

    typedef struct packed {
        logic signed [PW-1:0]  det;
        logic signed [PW-1:0]  s;
        logic signed [PW-1:0]  t;
        logic signed [NDW-1:0] denom;
        logic signed [NDW-1:0] nu1;
        logic signed [NDW-1:0] nu2;
        logic signed [NDW-1:0] sa1;
        logic signed [NDW-1:0] sb1;
    } dets_t;

    typedef struct packed {
        logic [WW-1:0] ws;
        logic [WW-1:0] wt;
        feat_t         feature;
        logic          degen;
    } res_t;

    // ------------------------------------------------------------------
    // Stage valid bits and per-stage advance
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vin;
    logic [NS-1:0] en;

    assign vin          = {vld_reg[NS-2:0], s_tvalid};
    assign en[NS-1]     = !vld_reg[NS-1] || m_tready;
    assign s_tready     = en[ST_DIFF];
    assign m_tvalid     = vld_reg[NS-1];

    // a stage moves when it is empty or the next one moves
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vin[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Geometry carried alongside: vertex A, point P, edges
    // ------------------------------------------------------------------
    geo_t              geo_reg [0:ST_NEAR];
    geo_t              geo_c;
    logic [2:0][E-1:0] df_c;
    logic [2:0][E-1:0] df_reg;

    always_comb
    begin
        logic [C-1:0] pv, av, bv, cv;
        for (int i = 0; i < 3; i++)
        begin
            pv = s_tdata[i*C +: C];
            av = s_tdata[(3+i)*C +: C];
            bv = s_tdata[(6+i)*C +: C];
            cv = s_tdata[(9+i)*C +: C];
            geo_c.va[i] = av;
            geo_c.pt[i] = pv;
            geo_c.e0[i] = {bv[C-1], bv} - {av[C-1], av};
            geo_c.e1[i] = {cv[C-1], cv} - {av[C-1], av};
            df_c[i]     = {av[C-1], av} - {pv[C-1], pv};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DIFF])
        begin
            geo_reg[ST_DIFF] <= geo_c;
            df_reg           <= df_c;
        end
    end

    for (genvar k = 1; k <= ST_NEAR; k++) begin : g_geo
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                geo_reg[k] <= geo_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Component products, then Gram sums
    // ------------------------------------------------------------------
    logic [4:0][2:0][SQW-1:0] prd_c;
    logic [4:0][2:0][SQW-1:0] prd_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prd_c[Q_A00][i] = $signed(geo_reg[ST_DIFF].e0[i]) * $signed(geo_reg[ST_DIFF].e0[i]);
            prd_c[Q_A01][i] = $signed(geo_reg[ST_DIFF].e0[i]) * $signed(geo_reg[ST_DIFF].e1[i]);
            prd_c[Q_A11][i] = $signed(geo_reg[ST_DIFF].e1[i]) * $signed(geo_reg[ST_DIFF].e1[i]);
            prd_c[Q_B0][i]  = $signed(df_reg[i]) * $signed(geo_reg[ST_DIFF].e0[i]);
            prd_c[Q_B1][i]  = $signed(df_reg[i]) * $signed(geo_reg[ST_DIFF].e1[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            prd_reg <= prd_c;
        end
    end

    logic [4:0][DW-1:0] sum_c;
    logic [4:0][DW-1:0] sum_reg [ST_SUM:ST_DETS];

    always_comb
    begin
        for (int q = 0; q < 5; q++)
        begin
            sum_c[q] = $signed(prd_reg[q][0]) + $signed(prd_reg[q][1])
                     + $signed(prd_reg[q][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            sum_reg[ST_SUM] <= sum_c;
        end
    end

    for (genvar k = ST_PART; k <= ST_DETS; k++) begin : g_sum
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                sum_reg[k] <= sum_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Wide products in halves: four partials each, summed a stage later
    // ------------------------------------------------------------------
    logic [5:0][3:0][PPW-1:0] pp_c;
    logic [5:0][3:0][PPW-1:0] pp_reg;

    always_comb
    begin
        logic [DW-1:0] x, y;
        for (int j = 0; j < 6; j++)
        begin
            x = sum_reg[ST_SUM][PX[j]];
            y = sum_reg[ST_SUM][PY[j]];
            pp_c[j][0] = $signed(x[DW-1:H]) * $signed(y[DW-1:H]);
            pp_c[j][1] = $signed(x[DW-1:H]) * $signed({1'b0, y[H-1:0]});
            pp_c[j][2] = $signed({1'b0, x[H-1:0]}) * $signed(y[DW-1:H]);
            pp_c[j][3] = x[H-1:0] * y[H-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PART])
        begin
            pp_reg <= pp_c;
        end
    end

    logic [5:0][PW-1:0] wide_c;
    logic [5:0][PW-1:0] wide_reg;

    always_comb
    begin
        logic signed [PW-1:0] thh, tmid, tll;
        for (int j = 0; j < 6; j++)
        begin
            thh       = $signed(pp_reg[j][0]);
            tmid      = $signed(pp_reg[j][1]) + $signed(pp_reg[j][2]);
            tll       = $signed(pp_reg[j][3]);
            wide_c[j] = (thh <<< (2 * H)) + (tmid <<< H) + tll;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_WIDE])
        begin
            wide_reg <= wide_c;
        end
    end

    // ------------------------------------------------------------------
    // det, s, t and the edge-BC terms
    // ------------------------------------------------------------------
    dets_t dt_c;
    dets_t dt_reg;

    always_comb
    begin
        logic signed [PW-1:0]  dd;
        logic signed [NDW-1:0] a00, a01, a11, b0, b1, sa0, sb0;
        a00 = $signed(sum_reg[ST_WIDE][Q_A00]);
        a01 = $signed(sum_reg[ST_WIDE][Q_A01]);
        a11 = $signed(sum_reg[ST_WIDE][Q_A11]);
        b0  = $signed(sum_reg[ST_WIDE][Q_B0]);
        b1  = $signed(sum_reg[ST_WIDE][Q_B1]);
        dd  = $signed(wide_reg[0]) - $signed(wide_reg[1]);
        dt_c.det   = dd[PW-1] ? -dd : dd;
        dt_c.s     = $signed(wide_reg[2]) - $signed(wide_reg[3]);
        dt_c.t     = $signed(wide_reg[4]) - $signed(wide_reg[5]);
        dt_c.denom = a00 - (a01 <<< 1) + a11;
        sa0        = a01 + b0;
        sb0        = a01 + b1;
        dt_c.sa1   = a11 + b1;
        dt_c.sb1   = a00 + b0;
        dt_c.nu1   = dt_c.sa1 - sa0;
        dt_c.nu2   = dt_c.sb1 - sb0;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DETS])
        begin
            dt_reg <= dt_c;
        end
    end

    // ------------------------------------------------------------------
    // Region split: choose divider operands and weight sources
    // ------------------------------------------------------------------
    logic [1:0][PW-1:0] num_c, den_c;
    logic [1:0][PW-1:0] num_reg, den_reg;
    ctl_t               ctl_c;
    ctl_t               ctl_reg [ST_REG:ST_SEL-1];

    always_comb
    begin
        logic signed [PW-1:0] st_sum, a00, a11, b0, b1, nu1, nu2, denw;
        logic                 use_ab, use_ac;
        a00    = $signed(sum_reg[ST_DETS][Q_A00]);
        a11    = $signed(sum_reg[ST_DETS][Q_A11]);
        b0     = $signed(sum_reg[ST_DETS][Q_B0]);
        b1     = $signed(sum_reg[ST_DETS][Q_B1]);
        nu1    = dt_reg.nu1;
        nu2    = dt_reg.nu2;
        denw   = dt_reg.denom;
        st_sum = dt_reg.s + dt_reg.t;
        use_ab = 1'b0;
        use_ac = 1'b0;
        num_c  = '0;
        den_c  = '0;
        ctl_c  = '{s_sel: SEL_ZERO, t_sel: SEL_ZERO, feature: FEAT_VA, degen: 1'b0};

        if (st_sum <= dt_reg.det)
        begin
            if (dt_reg.s < 0)
            begin
                if (dt_reg.t < 0 && b0 < 0)
                    use_ab = 1'b1;
                else
                    use_ac = 1'b1;
            end
            else if (dt_reg.t < 0)
            begin
                use_ab = 1'b1;
            end
            else if (dt_reg.det == 0)
            begin
                ctl_c.degen = 1'b1;
            end
            else
            begin
                num_c[0]      = dt_reg.s;
                den_c[0]      = dt_reg.det;
                num_c[1]      = dt_reg.t;
                den_c[1]      = dt_reg.det;
                ctl_c.s_sel   = SEL_QA;
                ctl_c.t_sel   = SEL_QB;
                ctl_c.feature = FEAT_IN;
            end
        end
        else if (dt_reg.s < 0)
        begin
            if (nu1 > 0)
            begin
                if (nu1 >= denw)
                begin
                    ctl_c.s_sel   = SEL_ONE;
                    ctl_c.feature = FEAT_VB;
                end
                else
                begin
                    num_c[0]      = nu1;
                    den_c[0]      = denw;
                    ctl_c.s_sel   = SEL_QA;
                    ctl_c.t_sel   = SEL_INV_QA;
                    ctl_c.feature = FEAT_BC;
                end
            end
            else if (dt_reg.sa1 <= 0)
            begin
                ctl_c.t_sel   = SEL_ONE;
                ctl_c.feature = FEAT_VC;
            end
            else
            begin
                use_ac = 1'b1;
            end
        end
        else if (dt_reg.t < 0)
        begin
            if (nu2 > 0)
            begin
                if (nu2 >= denw)
                begin
                    ctl_c.t_sel   = SEL_ONE;
                    ctl_c.feature = FEAT_VC;
                end
                else
                begin
                    num_c[0]      = nu2;
                    den_c[0]      = denw;
                    ctl_c.s_sel   = SEL_INV_QA;
                    ctl_c.t_sel   = SEL_QA;
                    ctl_c.feature = FEAT_BC;
                end
            end
            else if (dt_reg.sb1 <= 0)
            begin
                ctl_c.s_sel   = SEL_ONE;
                ctl_c.feature = FEAT_VB;
            end
            else
            begin
                use_ab = 1'b1;
            end
        end
        else
        begin
            if (nu1 <= 0)
            begin
                ctl_c.t_sel   = SEL_ONE;
                ctl_c.feature = FEAT_VC;
            end
            else if (nu1 >= denw)
            begin
                ctl_c.s_sel   = SEL_ONE;
                ctl_c.feature = FEAT_VB;
            end
            else
            begin
                num_c[0]      = nu1;
                den_c[0]      = denw;
                ctl_c.s_sel   = SEL_QA;
                ctl_c.t_sel   = SEL_INV_QA;
                ctl_c.feature = FEAT_BC;
            end
        end

        // nearest on edge AB: vertex A, vertex B or a point between
        if (use_ab && b0 < 0)
        begin
            if (dt_reg.sb1 <= 0)
            begin
                ctl_c.s_sel   = SEL_ONE;
                ctl_c.feature = FEAT_VB;
            end
            else
            begin
                num_c[0]      = -b0;
                den_c[0]      = a00;
                ctl_c.s_sel   = SEL_QA;
                ctl_c.feature = FEAT_AB;
            end
        end

        // nearest on edge AC
        if (use_ac && b1 < 0)
        begin
            if (dt_reg.sa1 <= 0)
            begin
                ctl_c.t_sel   = SEL_ONE;
                ctl_c.feature = FEAT_VC;
            end
            else
            begin
                num_c[0]      = -b1;
                den_c[0]      = a11;
                ctl_c.t_sel   = SEL_QA;
                ctl_c.feature = FEAT_AC;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_REG])
        begin
            num_reg         <= num_c;
            den_reg         <= den_c;
            ctl_reg[ST_REG] <= ctl_c;
        end
    end

    for (genvar k = ST_CLMP; k < ST_SEL; k++) begin : g_ctl
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Clamp numerator into [0, den] (divisor 1 if den <= 0), add half a divisor
    // ------------------------------------------------------------------
    logic [1:0][DVW-1:0] dv_n_reg [0:DN];
    logic [1:0][DNW-1:0] dv_d_reg [0:DN];
    logic [1:0][QW-1:0]  dv_q_reg [0:DN];
    logic [1:0][DVW-1:0] cl_n_c;
    logic [1:0][DNW-1:0] cl_d_c;

    always_comb
    begin
        logic signed [PW-1:0] nm, dn;
        logic [DNW-1:0]       cn, cd;
        for (int l = 0; l < 2; l++)
        begin
            nm = $signed(num_reg[l]);
            dn = $signed(den_reg[l]);
            if (dn <= 0)
            begin
                cn = '0;
                cd = DNW'(1);
            end
            else
            begin
                cd = dn[DNW-1:0];
                if (nm < 0)
                    cn = '0;
                else if (nm > dn)
                    cn = dn[DNW-1:0];
                else
                    cn = nm[DNW-1:0];
            end
            cl_d_c[l] = cd;
            cl_n_c[l] = ({{(DVW-DNW){1'b0}}, cn} << W)
                      + {{(DVW-DNW+1){1'b0}}, cd[DNW-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_CLMP])
        begin
            dv_n_reg[0] <= cl_n_c;
            dv_d_reg[0] <= cl_d_c;
            dv_q_reg[0] <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < DN; j++) begin : g_div
        localparam int BI = QW - 1 - j;
        logic [1:0][DVW-1:0] n_nx;
        logic [1:0][QW-1:0]  q_nx;

        always_comb
        begin
            logic [DVW-1:0] dsh;
            for (int l = 0; l < 2; l++)
            begin
                dsh     = {{(DVW-DNW){1'b0}}, dv_d_reg[j][l]} << BI;
                n_nx[l] = dv_n_reg[j][l];
                q_nx[l] = dv_q_reg[j][l];
                if (dv_n_reg[j][l] >= dsh)
                begin
                    n_nx[l]     = dv_n_reg[j][l] - dsh;
                    q_nx[l][BI] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_DIV+j])
            begin
                dv_n_reg[j+1] <= n_nx;
                dv_d_reg[j+1] <= dv_d_reg[j];
                dv_q_reg[j+1] <= q_nx;
            end
        end
    end

    // ------------------------------------------------------------------
    // Weights from quotients
    // ------------------------------------------------------------------
    function automatic logic [WW-1:0] pick_w(input sel_t sel, input logic [WW-1:0] qa,
                                             input logic [WW-1:0] qb);
        logic [WW-1:0] one;
        one = WW'(1) << W;
        case (sel)
            SEL_ZERO:   pick_w = '0;
            SEL_ONE:    pick_w = one;
            SEL_QA:     pick_w = qa;
            SEL_QB:     pick_w = qb;
            SEL_INV_QA: pick_w = one - qa;
            default:    pick_w = '0;
        endcase
    endfunction

    res_t res_c;
    res_t res_reg [ST_SEL:ST_OUT];

    always_comb
    begin
        res_c.ws      = pick_w(ctl_reg[ST_SEL-1].s_sel, dv_q_reg[DN][0][WW-1:0],
                               dv_q_reg[DN][1][WW-1:0]);
        res_c.wt      = pick_w(ctl_reg[ST_SEL-1].t_sel, dv_q_reg[DN][0][WW-1:0],
                               dv_q_reg[DN][1][WW-1:0]);
        res_c.feature = ctl_reg[ST_SEL-1].feature;
        res_c.degen   = ctl_reg[ST_SEL-1].degen;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SEL])
        begin
            res_reg[ST_SEL] <= res_c;
        end
    end

    for (genvar k = ST_MUL; k <= ST_OUT; k++) begin : g_res
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                res_reg[k] <= res_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Nearest point: A + round(s*e0 + t*e1), saturated
    // ------------------------------------------------------------------
    logic [2:0][MW-1:0] ms_c, mt_c, ms_reg, mt_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ms_c[i] = $signed({1'b0, res_reg[ST_SEL].ws}) * $signed(geo_reg[ST_SEL].e0[i]);
            mt_c[i] = $signed({1'b0, res_reg[ST_SEL].wt}) * $signed(geo_reg[ST_SEL].e1[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            ms_reg <= ms_c;
            mt_reg <= mt_c;
        end
    end

    logic [2:0][C-1:0] near_c;
    logic [2:0][C-1:0] near_reg [ST_NEAR:ST_OUT];

    always_comb
    begin
        logic signed [AW-1:0] acc, nv;
        for (int i = 0; i < 3; i++)
        begin
            acc = $signed(ms_reg[i]) + $signed(mt_reg[i]);
            acc = (acc + $signed(HALF)) >>> W;
            nv  = $signed(geo_reg[ST_MUL].va[i]) + acc;
            if (nv < NLO)
                nv = NLO;
            else if (nv > NHI)
                nv = NHI;
            near_c[i] = nv[C-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_NEAR])
        begin
            near_reg[ST_NEAR] <= near_c;
        end
    end

    for (genvar k = ST_SQ; k <= ST_OUT; k++) begin : g_near
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                near_reg[k] <= near_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Squared distance from the rounded point
    // ------------------------------------------------------------------
    logic [2:0][SQW-1:0] sq_c, sq_reg;

    always_comb
    begin
        logic [E-1:0] dd;
        for (int i = 0; i < 3; i++)
        begin
            dd = {near_reg[ST_NEAR][i][C-1], near_reg[ST_NEAR][i]}
               - {geo_reg[ST_NEAR].pt[i][C-1], geo_reg[ST_NEAR].pt[i]};
            sq_c[i] = $signed(dd) * $signed(dd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SQ])
        begin
            sq_reg <= sq_c;
        end
    end

    logic [SQW+1:0] dist_c;
    logic [DSW-1:0] dist_reg;

    assign dist_c = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            dist_reg <= dist_c[DSW-1:0];
        end
    end

    assign m_tdata = OUT_W'({res_reg[ST_OUT].wt, res_reg[ST_OUT].ws, dist_reg,
                             near_reg[ST_OUT][2], near_reg[ST_OUT][1],
                             near_reg[ST_OUT][0]});
    assign m_tuser = {res_reg[ST_OUT].degen, res_reg[ST_OUT].feature};

endmodule

// ===== tb/point_triangle_closest_point_tb.sv =====
// ----------------------------------------------------------------------------
// point_triangle_closest_point_tb
// Self-checking bench for the triangle closest-point pipeline: directed
// corner triangles, then random point-triangle pairs, with random gaps on both
// stream sides, a long output stall and a drain pause. Each output beat is
// compared field by field against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module point_triangle_closest_point_tb;

    import ptcp_pkg::*;

    localparam int CB      = 16;
    localparam int WF      = 16;
    localparam int DW_IN   = ((12*CB+7)/8)*8;
    localparam int DW_OUT  = ((5*CB+2*WF+4+7)/8)*8;
    localparam int LATENCY = WF + 15;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [WF:0] W_ONE = (WF+1)'(1) << WF;

    typedef struct packed {
        logic        degen;
        feat_t       feature;
        logic [WF:0] wt;
        logic [WF:0] ws;
        logic [33:0] dist_sq;
        logic [CB-1:0] nz;
        logic [CB-1:0] ny;
        logic [CB-1:0] nx;
    } closest_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [DW_IN-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [DW_OUT-1:0] m_tdata;
    logic [3:0] m_tuser;

    closest_t nearest_q[$];
    int  fail_count;
    int  beats_in;
    int  beats_out;
    int  idle_cycles;
    bit  hold_out;     // long receiver hold-off request
    bit  stim_done;
    int  feat_seen[7];

    point_triangle_closest_point u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // round(num/den) at WF fraction bits, half up, num clamped into [0, den]
    function automatic logic [WF:0] weight_ratio(logic signed [127:0] num,
                                                 logic signed [127:0] den);
        logic signed [127:0] n;
        if (den <= 0)
            return '0;
        n = num;
        if (n < 0)
            n = 0;
        if (n > den)
            n = den;
        n = ((n <<< WF) + (den >>> 1)) / den;
        return n[WF:0];
    endfunction

    function automatic void edge_ab(logic signed [63:0] b0, logic signed [63:0] a00,
                                    output logic [WF:0] s, output logic [WF:0] t,
                                    output feat_t f);
        t = '0;
        if (b0 >= 0)
        begin
            s = '0;
            f = FEAT_VA;
        end
        else if (-b0 >= a00)
        begin
            s = W_ONE;
            f = FEAT_VB;
        end
        else
        begin
            s = weight_ratio(-b0, a00);
            f = FEAT_AB;
        end
    endfunction

    function automatic void edge_ac(logic signed [63:0] b1, logic signed [63:0] a11,
                                    output logic [WF:0] s, output logic [WF:0] t,
                                    output feat_t f);
        s = '0;
        if (b1 >= 0)
        begin
            t = '0;
            f = FEAT_VA;
        end
        else if (-b1 >= a11)
        begin
            t = W_ONE;
            f = FEAT_VC;
        end
        else
        begin
            t = weight_ratio(-b1, a11);
            f = FEAT_AC;
        end
    endfunction

    // Predict the closest point, distance, weights and feature for one beat.
    function automatic closest_t predict_closest(logic [DW_IN-1:0] beat);
        logic signed [63:0] p[3], va[3], e0[3], e1[3], df[3];
        logic signed [63:0] a00, a01, a11, b0, b1, tmp0, tmp1, numer, denom, acc, n, d;
        logic signed [127:0] det, s, t;
        logic [WF:0] ws, wt, q;
        logic [63:0] dsq;
        feat_t f;
        closest_t r;
        a00 = 0; a01 = 0; a11 = 0; b0 = 0; b1 = 0;
        dsq = 0;
        r = '0;
        for (int i = 0; i < 3; i++)
        begin
            p[i]  = $signed(beat[i*CB +: CB]);
            va[i] = $signed(beat[(3+i)*CB +: CB]);
            e0[i] = $signed(beat[(6+i)*CB +: CB]) - va[i];
            e1[i] = $signed(beat[(9+i)*CB +: CB]) - va[i];
            df[i] = va[i] - p[i];
            a00 += e0[i]*e0[i];
            a01 += e0[i]*e1[i];
            a11 += e1[i]*e1[i];
            b0  += df[i]*e0[i];
            b1  += df[i]*e1[i];
        end
        det = 128'(a00)*128'(a11) - 128'(a01)*128'(a01);
        if (det < 0)
            det = -det;
        s = 128'(a01)*128'(b1) - 128'(a11)*128'(b0);
        t = 128'(a01)*128'(b0) - 128'(a00)*128'(b1);
        denom = a00 - 2*a01 + a11;
        if (s + t <= det)
        begin
            if (s < 0)
            begin
                if (t < 0 && b0 < 0)
                    edge_ab(b0, a00, ws, wt, f);
                else
                    edge_ac(b1, a11, ws, wt, f);
            end
            else if (t < 0)
                edge_ab(b0, a00, ws, wt, f);
            else if (det == 0)
            begin
                r.degen = 1'b1;
                ws = '0; wt = '0; f = FEAT_VA;
            end
            else
            begin
                ws = weight_ratio(s, det);
                wt = weight_ratio(t, det);
                f  = FEAT_IN;
            end
        end
        else if (s < 0)
        begin
            tmp0 = a01 + b0;
            tmp1 = a11 + b1;
            if (tmp1 > tmp0)
            begin
                numer = tmp1 - tmp0;
                if (numer >= denom)
                begin
                    ws = W_ONE; wt = '0; f = FEAT_VB;
                end
                else
                begin
                    q = weight_ratio(numer, denom);
                    ws = q; wt = W_ONE - q; f = FEAT_BC;
                end
            end
            else if (tmp1 <= 0)
            begin
                ws = '0; wt = W_ONE; f = FEAT_VC;
            end
            else
                edge_ac(b1, a11, ws, wt, f);
        end
        else if (t < 0)
        begin
            tmp0 = a01 + b1;
            tmp1 = a00 + b0;
            if (tmp1 > tmp0)
            begin
                numer = tmp1 - tmp0;
                if (numer >= denom)
                begin
                    ws = '0; wt = W_ONE; f = FEAT_VC;
                end
                else
                begin
                    q = weight_ratio(numer, denom);
                    ws = W_ONE - q; wt = q; f = FEAT_BC;
                end
            end
            else if (tmp1 <= 0)
            begin
                ws = W_ONE; wt = '0; f = FEAT_VB;
            end
            else
                edge_ab(b0, a00, ws, wt, f);
        end
        else
        begin
            numer = a11 + b1 - a01 - b0;
            if (numer <= 0)
            begin
                ws = '0; wt = W_ONE; f = FEAT_VC;
            end
            else if (numer >= denom)
            begin
                ws = W_ONE; wt = '0; f = FEAT_VB;
            end
            else
            begin
                q = weight_ratio(numer, denom);
                ws = q; wt = W_ONE - q; f = FEAT_BC;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = $signed({1'b0, ws})*e0[i] + $signed({1'b0, wt})*e1[i];
            n = va[i] + ((acc + (64'sd1 <<< (WF-1))) >>> WF);
            if (n < -(64'sd1 <<< (CB-1)))
                n = -(64'sd1 <<< (CB-1));
            if (n > (64'sd1 <<< (CB-1)) - 1)
                n = (64'sd1 <<< (CB-1)) - 1;
            d = n - p[i];
            dsq += d*d;
            case (i)
                0: r.nx = n[CB-1:0];
                1: r.ny = n[CB-1:0];
                default: r.nz = n[CB-1:0];
            endcase
        end
        r.dist_sq = dsq[33:0];
        r.ws      = ws;
        r.wt      = wt;
        r.feature = f;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Send one beat, holding tvalid until the block takes it. Keep tvalid
    // high into the next beat when there is no gap.
    task automatic send_query(logic [CB-1:0] c[12], bit no_gap = 0);
        logic [DW_IN-1:0] beat;
        int gap;
        beat = '0;
        for (int i = 0; i < 12; i++)
            beat[i*CB +: CB] = c[i];
        gap = no_gap ? 0 : gap_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        nearest_q.push_back(predict_closest(beat));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_in++;
    endtask

    task automatic drain_wait();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge clk);
    endtask

    // Build a triangle from vertex A and the edges e0 and e1; point P is given directly.
    task automatic send_tri(int ax, int ay, int az, int e0x, int e0y, int e0z,
                            int e1x, int e1y, int e1z, int px, int py, int pz);
        logic [CB-1:0] c[12];
        c[0] = CB'(px); c[1] = CB'(py); c[2] = CB'(pz);
        c[3] = CB'(ax); c[4] = CB'(ay); c[5] = CB'(az);
        c[6] = CB'(ax+e0x); c[7] = CB'(ay+e0y); c[8] = CB'(az+e0z);
        c[9] = CB'(ax+e1x); c[10] = CB'(ay+e1y); c[11] = CB'(az+e1z);
        send_query(c);
    endtask

    task automatic test_directed();
        logic [CB-1:0] c[12];
        // right triangle, legs 256, in z=0; probe each of the seven regions
        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 100);      // interior
        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, -50, -50, 0);      // vertex A
        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 400, -30, 0);      // vertex B
        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, -30, 400, 0);      // vertex C
        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 100, -80, 7);      // edge AB
        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, -80, 100, 7);      // edge AC
        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 200, 200, -9);     // edge BC
        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 128, 128, 0);      // on BC exactly
        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0);          // point on A
        // degenerate: collinear, coincident
        send_tri(10, 20, 30, 100, 100, 100, 200, 200, 200, 5, 5, 5);
        send_tri(-7, 9, 3, 0, 0, 0, 0, 0, 0, 500, -500, 12);
        // extremes of the coordinate range
        for (int i = 0; i < 12; i++)
            c[i] = 16'h8000;
        send_query(c);
        for (int i = 0; i < 12; i++)
            c[i] = 16'h7fff;
        send_query(c);
        c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
              16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff};
        send_query(c);
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
              16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        send_query(c);
        c = '{16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h8000,
              16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000};
        send_query(c);
        drain_wait();
    endtask

    task automatic send_random(int count);
        logic [CB-1:0] c[12];
        int span;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 3))
                0: for (int i = 0; i < 12; i++)
                       c[i] = CB'($urandom);       // full range
                1: begin                           // local triangle near point
                    span = 1 << $urandom_range(2, 12);
                    for (int i = 0; i < 3; i++)
                        c[i] = CB'($urandom_range(0, 16'hffff));
                    for (int i = 3; i < 12; i++)
                        c[i] = CB'(int'(c[i % 3]) + int'($urandom_range(0, 2*span)) - span);
                end
                2: begin                           // near-degenerate: C near line AB
                    for (int i = 0; i < 9; i++)
                        c[i] = CB'(int'($urandom_range(0, 4095)) - 2048);
                    for (int i = 0; i < 3; i++)
                        c[9+i] = CB'(2*c[6+i] - c[3+i] + ($urandom_range(0, 9) == 0));
                end
                default: begin                     // small triangle, small coords
                    for (int i = 0; i < 12; i++)
                        c[i] = CB'(int'($urandom_range(0, 1023)) - 512);
                end
            endcase
            send_query(c, $urandom_range(0, 4) == 0);
        end
    endtask

    task automatic test_random();
        send_random(900);
    endtask

    // Hold the output off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        fork
            begin
                hold_out = 1'b1;
                repeat (3*LATENCY) @(posedge clk);
                hold_out = 1'b0;
            end
            send_random(120);
        join
        drain_wait();
    endtask

    task automatic test_burst();
        logic [CB-1:0] c[12];
        for (int k = 0; k < 100; k++)
        begin
            for (int i = 0; i < 12; i++)
                c[i] = CB'($urandom);
            send_query(c, 1'b1);
        end
        drain_wait();
    endtask

    // Output side: random tready with long stalls, plus the forced hold-off.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= !hold_out;
            @(posedge clk);
            if (!hold_out && $urandom_range(0, 2) == 0)
            begin
                stall = gap_len();
                if (stall != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // Compare each output beat with the oldest prediction.
    always @(posedge clk)
    begin
        closest_t exp_r;
        closest_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            got = {m_tuser[3], feat_t'(m_tuser[2:0]), m_tdata[5*CB+2*WF+3:0]};
            if (nearest_q.size() == 0)
            begin
                $display("%0t: output beat with none expected: %h", $time, got);
                fail_count++;
            end
            else
            begin
                exp_r = nearest_q.pop_front();
                feat_seen[exp_r.feature]++;
                if (got.nx !== exp_r.nx || got.ny !== exp_r.ny || got.nz !== exp_r.nz)
                begin
                    $display("%0t: near point exp (%h,%h,%h) got (%h,%h,%h)", $time,
                             exp_r.nx, exp_r.ny, exp_r.nz, got.nx, got.ny, got.nz);
                    fail_count++;
                end
                if (got.dist_sq !== exp_r.dist_sq)
                begin
                    $display("%0t: dist_squared exp %0d got %0d", $time,
                             exp_r.dist_sq, got.dist_sq);
                    fail_count++;
                end
                if (got.ws !== exp_r.ws || got.wt !== exp_r.wt)
                begin
                    $display("%0t: weights exp s=%h t=%h got s=%h t=%h", $time,
                             exp_r.ws, exp_r.wt, got.ws, got.wt);
                    fail_count++;
                end
                if (got.feature !== exp_r.feature || got.degen !== exp_r.degen)
                begin
                    $display("%0t: feature/degenerate exp %0d/%0d got %0d/%0d", $time,
                             exp_r.feature, exp_r.degen, got.feature, got.degen);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d beats outstanding", $time, nearest_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        fail_count  = 0;
        beats_in    = 0;
        beats_out   = 0;
        idle_cycles = 0;
        hold_out    = 1'b0;
        stim_done   = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_burst();
        stim_done = 1'b1;
        drain_wait();
        repeat (2*LATENCY) @(posedge clk);
        $display("Ran %0d queries (%0d results checked): directed regions, extremes,",
                 beats_in, beats_out);
        $display("  random and near-degenerate triangles; features seen %0d %0d %0d %0d %0d %0d %0d",
                 feat_seen[0], feat_seen[1], feat_seen[2], feat_seen[3],
                 feat_seen[4], feat_seen[5], feat_seen[6]);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
